// ===== hdl/pee_pkg.sv =====
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types and codes for the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNDERFLOW = 3'd1;
	localparam logic [2:0] ST_DIVZERO   = 3'd2;
	localparam logic [2:0] ST_BADCHAR   = 3'd3;
	localparam logic [2:0] ST_OVERFLOW  = 3'd4;
	localparam logic [2:0] ST_EMPTY     = 3'd5;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_DIV   = 8'h2F;
	localparam logic [7:0] CH_POW   = 8'h5E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_POW = 3'd4;

	typedef enum logic [1:0] {
		K_DIGIT = 2'd0,
		K_SPACE = 2'd1,
		K_OPER  = 2'd2,
		K_BAD   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] digit;
		logic [2:0] op;
		logic       last;
	} cmd_t;

	localparam int CMD_W = $bits(cmd_t);

endpackage

// ===== hdl/pee_ram.sv =====
// ----------------------------------------------------------------------------
// pee_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module pee_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/pee_front.sv =====
// ----------------------------------------------------------------------------
// pee_front
// Accepts characters, classifies them and writes commands into a small queue.
// ----------------------------------------------------------------------------
module pee_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        char_code,
	input  logic              last_char,
	output logic              q_valid,
	input  logic              q_pop,
	output pee_pkg::cmd_t     q_cmd
);
	import pee_pkg::*;

	cmd_t       fifo_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	cmd_t       c;
	logic       push;

	always_comb begin
		c.kind  = K_BAD;
		c.digit = 4'(char_code - CH_ZERO);
		c.op    = OP_ADD;
		c.last  = last_char;
		if (char_code >= CH_ZERO && char_code <= CH_NINE)
			c.kind = K_DIGIT;
		else if (char_code == CH_SPACE)
			c.kind = K_SPACE;
		else begin
			case (char_code)
				CH_PLUS:  begin c.kind = K_OPER; c.op = OP_ADD; end
				CH_MINUS: begin c.kind = K_OPER; c.op = OP_SUB; end
				CH_MUL:   begin c.kind = K_OPER; c.op = OP_MUL; end
				CH_DIV:   begin c.kind = K_OPER; c.op = OP_DIV; end
				CH_POW:   begin c.kind = K_OPER; c.op = OP_POW; end
				default:  c.kind = K_BAD;
			endcase
		end
	end

	assign in_stall = (cnt_q == 3'd4);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 3'd0);
	assign q_cmd    = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 2'd1;
			if (q_pop)
				rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(q_pop);
		end
	end

endmodule

// ===== hdl/pee_alu.sv =====
// ----------------------------------------------------------------------------
// pee_alu
// Multi-cycle arithmetic: add/sub in one step, multiply, restoring divide
// one bit per cycle, and square-and-multiply power with a multiply phase and a square phase per exponent bit.
// ----------------------------------------------------------------------------
module pee_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [2:0]  op,
	input  logic [31:0] lhs,
	input  logic [31:0] rhs,
	output logic        done,
	output logic [31:0] res
);
	import pee_pkg::*;

	localparam logic [1:0] A_IDLE = 2'd0;
	localparam logic [1:0] A_DIV  = 2'd1;
	localparam logic [1:0] A_POW  = 2'd2;
	localparam logic [1:0] A_MULW = 2'd3;

	logic [1:0]  st_q;
	logic [5:0]  n_q;
	logic [31:0] a_q, b_q, r_q, acc_q;
	logic        neg_q;
	logic [32:0] trial;
	logic [31:0] la, lb;

	assign la    = lhs[31] ? 32'(0 - lhs) : lhs;
	assign lb    = rhs[31] ? 32'(0 - rhs) : rhs;
	assign trial = {r_q, a_q[31]} - {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= A_IDLE;
			done <= 1'b0;
			n_q  <= '0;
		end else begin
			done <= 1'b0;
			case (st_q)
				A_IDLE: begin
					if (start) begin
						case (op)
							OP_ADD: begin res <= lhs + rhs; done <= 1'b1; end
							OP_SUB: begin res <= lhs - rhs; done <= 1'b1; end
							OP_MUL: begin
								a_q <= lhs; b_q <= rhs; st_q <= A_MULW;
							end
							OP_DIV: begin
								a_q <= la; b_q <= lb; r_q <= '0;
								neg_q <= lhs[31] ^ rhs[31];
								n_q <= 6'd32; st_q <= A_DIV;
							end
							default: begin
								if (rhs == 32'd0 || rhs[31]) begin
									res <= 32'd1; done <= 1'b1;
								end else begin
									a_q <= lhs; b_q <= rhs; acc_q <= 32'd1;
									n_q <= 6'd0; st_q <= A_POW;
									neg_q <= 1'b0;
								end
							end
						endcase
					end
				end
				A_MULW: begin
					res  <= a_q * b_q;
					done <= 1'b1;
					st_q <= A_IDLE;
				end
				A_DIV: begin
					a_q <= {a_q[30:0], ~trial[32]};
					r_q <= trial[32] ? {r_q[30:0], a_q[31]} : trial[31:0];
					n_q <= n_q - 6'd1;
					if (n_q == 6'd1) begin
						st_q <= A_IDLE;
						done <= 1'b1;
						res  <= neg_q ? 32'(0 - {a_q[30:0], ~trial[32]})
							: {a_q[30:0], ~trial[32]};
					end
				end
				default: begin
					// neg_q toggles between multiply-into-acc and square phases
					if (!neg_q) begin
						if (b_q == 32'd0) begin
							res <= acc_q; done <= 1'b1; st_q <= A_IDLE;
						end else begin
							if (b_q[0])
								acc_q <= acc_q * a_q;
							neg_q <= 1'b1;
						end
					end else begin
						a_q   <= a_q * a_q;
						b_q   <= b_q >> 1;
						neg_q <= 1'b0;
					end
				end
			endcase
		end
	end

endmodule

// ===== hdl/pee_back.sv =====
// ----------------------------------------------------------------------------
// pee_back
// Executes commands: number build, operand stack in RAM, operator sequencing,
// error tracking and result output register.
// ----------------------------------------------------------------------------
module pee_back #(
	parameter int STACK_DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_pop,
	input  pee_pkg::cmd_t       q_cmd,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  value,
	output logic [2:0]          status
);
	import pee_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD1  = 3'd1;
	localparam logic [2:0] S_RD2  = 3'd2;
	localparam logic [2:0] S_EXEC = 3'd3;
	localparam logic [2:0] S_WAIT = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;
	localparam logic [2:0] S_TOP  = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	logic [2:0]    st_q;
	cmd_t          cmd_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   num_q, rhs_q;
	logic          act_q;
	logic [2:0]    err_q;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wdata, rdata;
	logic          alu_start, alu_done;
	logic [31:0]   alu_res;
	logic          full;

	assign full = (cnt_q == CW'(STACK_DEPTH));

	pee_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	pee_alu u_alu (
		.clk(clk), .arst_n(arst_n), .start(alu_start), .op(cmd_q.op),
		.lhs(rdata), .rhs(rhs_q), .done(alu_done), .res(alu_res)
	);

	assign q_pop     = (st_q == S_IDLE) && q_valid && !out_valid;
	assign alu_start = (st_q == S_EXEC);

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[AW-1:0];
		wdata = num_q;
		raddr = AW'(cnt_q - CW'(1));
		if (st_q == S_RD2)
			raddr = AW'(cnt_q - CW'(2));
		if (st_q == S_IDLE && q_pop && err_q == ST_OK && act_q && !full
			&& (q_cmd.kind == K_SPACE || q_cmd.kind == K_OPER))
			we = 1'b1;
		if (st_q == S_FIN && err_q == ST_OK && act_q && !full)
			we = 1'b1;
		if (st_q == S_WAIT && alu_done && !full)
			we = 1'b1;
		if (st_q == S_WAIT)
			wdata = alu_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			cnt_q     <= '0;
			num_q     <= '0;
			act_q     <= 1'b0;
			err_q     <= ST_OK;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (q_pop) begin
						cmd_q <= q_cmd;
						st_q  <= q_cmd.last ? S_FIN : S_IDLE;
						if (err_q == ST_OK) begin
							case (q_cmd.kind)
								K_DIGIT: begin
									num_q <= 32'(num_q * 32'd10) + 32'(q_cmd.digit);
									act_q <= 1'b1;
								end
								K_BAD: err_q <= ST_BADCHAR;
								default: begin
									act_q <= 1'b0;
									num_q <= '0;
									if (act_q) begin
										if (full)
											err_q <= ST_OVERFLOW;
										else
											cnt_q <= cnt_q + CW'(1);
									end
									if (q_cmd.kind == K_OPER
										&& !(act_q && full)) begin
										if ((act_q ? cnt_q + CW'(1) : cnt_q)
											< CW'(2))
											err_q <= ST_UNDERFLOW;
										else
											st_q <= S_RD1;
									end
								end
							endcase
						end
					end
				end
				S_RD1: st_q <= S_RD2;
				S_RD2: begin
					rhs_q <= rdata;
					if (cmd_q.op == OP_DIV && rdata == 32'd0) begin
						err_q <= ST_DIVZERO;
						cnt_q <= cnt_q - CW'(2);
						st_q  <= cmd_q.last ? S_FIN : S_IDLE;
					end else
						st_q <= S_EXEC;
				end
				S_EXEC: begin
					cnt_q <= cnt_q - CW'(2);
					st_q  <= S_WAIT;
				end
				S_WAIT: begin
					if (alu_done) begin
						if (full)
							err_q <= ST_OVERFLOW;
						else
							cnt_q <= cnt_q + CW'(1);
						st_q <= cmd_q.last ? S_FIN : S_IDLE;
					end
				end
				S_FIN: begin
					if (err_q == ST_OK && act_q) begin
						if (full)
							err_q <= ST_OVERFLOW;
						else
							cnt_q <= cnt_q + CW'(1);
					end
					st_q <= S_TOP;
				end
				S_TOP: st_q <= S_OUT;
				default: begin
					value     <= '0;
					status    <= err_q;
					if (err_q == ST_OK) begin
						if (cnt_q == '0)
							status <= ST_EMPTY;
						else
							value <= rdata;
					end
					out_valid <= 1'b1;
					cnt_q     <= '0;
					num_q     <= '0;
					act_q     <= 1'b0;
					err_q     <= ST_OK;
					st_q      <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/postfix_expression_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core
// Postfix integer evaluator: character front end, command queue, stack engine.
//
//   channel | signals                          | direction
//   in      | in_valid in_stall char_code last_char | into block
//   out     | out_valid out_stall value status | out of block
//
// Digits and spaces are handled in the back end's idle state; an operator
// reads its two operands from the stack, then starts the ALU and waits for it.
// A last item passes through the FIN and TOP states before the result register loads.
// The front queue holds four requests so the input keeps flowing meanwhile.
// Reset clears all control state; stack contents need no clearing.
// A held result stalls the back end only; the front keeps filling the queue.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_core #(
	parameter int STACK_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         char_code,
	input  logic               last_char,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value,
	output logic [2:0]         status
);
	import pee_pkg::*;

	logic q_valid, q_pop;
	cmd_t q_cmd;

	pee_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.char_code(char_code), .last_char(last_char),
		.q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
	);

	pee_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop),
		.q_cmd(q_cmd), .out_valid(out_valid), .out_stall(out_stall),
		.value(value), .status(status)
	);

endmodule

// ===== hdl/pee_checker.sv =====
// ----------------------------------------------------------------------------
// pee_checker
// Port-level checks for the postfix evaluator.
// ----------------------------------------------------------------------------
module pee_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] value,
	input logic [2:0]  status
);
	import pee_pkg::*;

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_EMPTY)
		else $error("status code out of range");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> value == 32'd0)
		else $error("nonzero value on error");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
		else $error("stalled result changed");

	a_no_back2back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("results closer than the back end allows");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("stalled request withdrawn");

endmodule

bind postfix_expression_evaluator_core pee_checker u_pee_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .value(value), .status(status)
);
